/* hw/rtl/tcw_pkg.sv */
// Shared types and constants for the text console writer.
package tcw_pkg;

  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 11;
  localparam int POS_W  = 11;
  localparam int CELL_W = 16;

  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
  localparam logic [CELL_W-1:0] TEXT_ATTR    = 16'h0700;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_CLEAR
  } tcw_state_e;

endpackage

/* hw/rtl/tcw_cmd_if.sv */
// Command channel: valid/ready handshake with the command payload.
interface tcw_cmd_if
  import tcw_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [CHAR_W-1:0] char_code;
  logic [IDX_W-1:0]  cell_index;

  modport source (output valid, output command, output char_code, output cell_index,
                  input ready);
  modport sink   (input valid, input command, input char_code, input cell_index,
                  output ready);
endinterface

/* hw/rtl/tcw_res_if.sv */
// Result channel: valid/ready handshake with the result payload.
interface tcw_res_if
  import tcw_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  cursor_pos;
  logic [CELL_W-1:0] cell_value;
  logic              scrolled;

  modport source (output valid, output cursor_pos, output cell_value, output scrolled,
                  input ready);
  modport sink   (input valid, input cursor_pos, input cell_value, input scrolled,
                  output ready);
endinterface

/* hw/rtl/tcw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/text_console_writer.sv */
// Text console writer: screen memory, cursor and command sequencer.
//
// Usage: commands arrive as beats on cmd_i (put character, clear screen,
// read one cell) and every command returns exactly one beat on res_o with
// the cursor position after the command, the read cell (zero otherwise)
// and a flag that tells whether the screen scrolled.
// A command is taken only while the sequencer is idle and the result
// register is empty or drained in the same cycle; puts that do not scroll
// and the unused code can follow every cycle while each result is taken,
// but a read holds off the next command until its result is loaded.
// A put without scroll and the unused code load the result register
// directly, a read passes through ST_READ and the registered RAM read,
// clear sweeps every cell (one cell written per cycle), and a put that
// scrolls sweeps the screen (each cycle reads one cell a row below and
// writes the previous one). The single write port of the screen RAM
// sets the sweep lengths. After reset the sequencer sweeps the whole
// screen with blank cells, all ROWS*COLUMNS of them (2000 at the default
// size), before the first command is taken. A stalled receiver holds the
// result register, and cmd_i.ready stays low until that beat is taken.
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tcw_cmd_if.sink   cmd_i,
  tcw_res_if.source res_o
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int COPY_CNT   = (ROWS - 1) * COLUMNS;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int CW         = $clog2(CELL_COUNT + 1);
  localparam int CLW        = $clog2(COLUMNS);
  localparam int RW         = $clog2(ROWS);

  tcw_state_e state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CLW-1:0]    col_q, col_d;
  logic [RW-1:0]     row_q, row_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic              res_valid_q, res_valid_d;
  logic [POS_W-1:0]  res_pos_q, res_pos_d;
  logic [CELL_W-1:0] res_value_q, res_value_d;
  logic              res_scrolled_q, res_scrolled_d;
  logic              rd_oob_q, rd_oob_d;
  logic              res_load;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  logic cmd_fire;
  logic is_newline;
  logic wrap;
  logic advance;
  logic last_row;
  logic sweep_end;
  logic scroll_end;

  assign cmd_i.ready = (state_q == ST_IDLE) && (!res_valid_q || res_o.ready);
  assign cmd_fire    = cmd_i.valid && cmd_i.ready;
  assign is_newline  = (cmd_i.char_code == NEWLINE_CODE);
  assign wrap        = !is_newline && (col_q == CLW'(COLUMNS - 1));
  assign advance     = is_newline || wrap;
  assign last_row    = (row_q == RW'(ROWS - 1));
  assign sweep_end   = (cnt_q == CW'(CELL_COUNT - 1));
  assign scroll_end  = (cnt_q == CW'(CELL_COUNT));

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELL_COUNT)
  ) u_screen (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (sweep_end) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_fire) begin
          case (cmd_i.command)
            CMD_PUT: begin
              if (advance && last_row) state_d = ST_SCROLL;
            end
            CMD_CLEAR: state_d = ST_CLEAR;
            CMD_READ:  state_d = ST_READ;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ:   state_d = ST_IDLE;
      ST_SCROLL: begin
        if (scroll_end) state_d = ST_IDLE;
      end
      ST_CLEAR: begin
        if (sweep_end) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath, memory control and result register loads.
  always_comb begin
    cnt_d          = cnt_q;
    col_d          = col_q;
    row_d          = row_q;
    pos_d          = pos_q;
    rd_oob_d       = rd_oob_q;
    res_load       = 1'b0;
    res_pos_d      = res_pos_q;
    res_value_d    = res_value_q;
    res_scrolled_d = res_scrolled_q;
    ram_we         = 1'b0;
    ram_waddr      = pos_q;
    ram_wdata      = TEXT_ATTR | CELL_W'(cmd_i.char_code);
    ram_raddr      = AW'(cmd_i.cell_index);
    case (state_q)
      ST_INIT, ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q[AW-1:0];
        ram_wdata = BLANK_CELL;
        cnt_d     = sweep_end ? '0 : cnt_q + 1'b1;
        if (sweep_end && state_q == ST_CLEAR) begin
          res_load       = 1'b1;
          res_pos_d      = POS_W'(pos_q);
          res_value_d    = '0;
          res_scrolled_d = 1'b0;
        end
      end
      ST_IDLE: begin
        if (cmd_fire) begin
          case (cmd_i.command)
            CMD_PUT: begin
              ram_we = !is_newline;
              if (advance) begin
                col_d = '0;
                if (last_row) begin
                  pos_d = AW'(COPY_CNT);
                end else begin
                  row_d = row_q + 1'b1;
                  pos_d = pos_q - AW'(col_q) + AW'(COLUMNS);
                end
              end else begin
                col_d = col_q + 1'b1;
                pos_d = pos_q + 1'b1;
              end
              // A scrolling put reports only once the sweep is done.
              if (!(advance && last_row)) begin
                res_load       = 1'b1;
                res_pos_d      = POS_W'(pos_d);
                res_value_d    = '0;
                res_scrolled_d = 1'b0;
              end
            end
            CMD_CLEAR: begin
              col_d = '0;
              row_d = '0;
              pos_d = '0;
            end
            CMD_READ: begin
              rd_oob_d = (32'(cmd_i.cell_index) >= CELL_COUNT);
            end
            default: begin
              res_load       = 1'b1;
              res_pos_d      = POS_W'(pos_q);
              res_value_d    = '0;
              res_scrolled_d = 1'b0;
            end
          endcase
        end
      end
      ST_READ: begin
        res_load       = 1'b1;
        res_pos_d      = POS_W'(pos_q);
        res_value_d    = rd_oob_q ? '0 : ram_rdata;
        res_scrolled_d = 1'b0;
      end
      ST_SCROLL: begin
        // Reads run one cell ahead of the write-back of the row above.
        ram_raddr = (cnt_q < CW'(COPY_CNT)) ? AW'(cnt_q + CW'(COLUMNS)) : '0;
        ram_we    = (cnt_q != '0);
        ram_waddr = AW'(cnt_q - 1'b1);
        ram_wdata = (cnt_q <= CW'(COPY_CNT)) ? ram_rdata : '0;
        cnt_d     = scroll_end ? '0 : cnt_q + 1'b1;
        if (scroll_end) begin
          res_load       = 1'b1;
          res_pos_d      = POS_W'(pos_q);
          res_value_d    = '0;
          res_scrolled_d = 1'b1;
        end
      end
      default: begin
        cnt_d = '0;
      end
    endcase
    res_valid_d = res_load ? 1'b1 : (res_o.ready ? 1'b0 : res_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      pos_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      col_q       <= col_d;
      row_q       <= row_d;
      pos_q       <= pos_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_oob_q <= rd_oob_d;
    if (res_load) begin
      res_pos_q      <= res_pos_d;
      res_value_q    <= res_value_d;
      res_scrolled_q <= res_scrolled_d;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.cursor_pos = res_pos_q;
  assign res_o.cell_value = res_value_q;
  assign res_o.scrolled   = res_scrolled_q;

  // A new result is never stored over one the receiver has not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!res_valid_q || res_o.ready))
    else $error("result register overwritten");

  // Commands are only taken while no sweep or read is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ready |-> (state_q == ST_IDLE))
    else $error("command taken while busy");

  // The cursor stays on the screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(col_q) < COLUMNS) && (32'(row_q) < ROWS))
    else $error("cursor off screen");

  // A scroll always leaves the cursor at the start of the bottom row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_scrolled_q) |-> (res_pos_q == POS_W'(COPY_CNT)))
    else $error("scroll reported with cursor off bottom row");

endmodule
